// File: hdl/pidq_pkg.sv
`timescale 1ns / 1ps

package pidq_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int REG_IDX_W      = 3;
	localparam int FLAGS_W        = 5;

	// Register map, one entry per word of the configuration space; index 7 has none.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_GAIN_WINDUP = 3'd3,
		REG_LIMIT_LOW   = 3'd4,
		REG_LIMIT_HIGH  = 3'd5,
		REG_FLAGS       = 3'd6
	} pidq_reg_t;

	// Last member is bit 0 of the control register.
	typedef struct packed {
		logic int_reset;
		logic anti_windup;
		logic pid_clamp;
		logic pi_clamp;
		logic pid_mode;
	} pidq_flags_t;

	localparam logic CMD_RUN   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL_I = 6'b000010,
		ST_MUL_P = 6'b000100,
		ST_MUL_W = 6'b001000,
		ST_MUL_D = 6'b010000,
		ST_OUT   = 6'b100000
	} pidq_state_t;

endpackage

// File: hdl/pidq_if.sv
`timescale 1ns / 1ps

interface pidq_step_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [DATA_WIDTH-1:0] error_in;

	modport source (output valid, output command, output error_in, input ready);
	modport sink   (input valid, input command, input error_in, output ready);
endinterface

interface pidq_drive_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] drive_out;

	modport source (output valid, output drive_out, input ready);
	modport sink   (input valid, input drive_out, output ready);
endinterface

// File: hdl/pidq_regs.sv
`timescale 1ns / 1ps

module pidq_regs import pidq_pkg::*; #(
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	parameter int ADDR_WIDTH  = 5,
	parameter int PDATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_WIDTH-1:0]  paddr,
	input  logic [PDATA_WIDTH-1:0] pwdata,
	output logic [PDATA_WIDTH-1:0] prdata,
	output logic                   pready,
	output logic [DATA_WIDTH-1:0]  gain_p,
	output logic [DATA_WIDTH-1:0]  gain_i,
	output logic [DATA_WIDTH-1:0]  gain_d,
	output logic [DATA_WIDTH-1:0]  gain_windup,
	output logic [DATA_WIDTH-1:0]  limit_low,
	output logic [DATA_WIDTH-1:0]  limit_high,
	output pidq_flags_t            flags
);

	localparam int IDX_LSB = ADDR_WIDTH - REG_IDX_W;

	logic [REG_IDX_W-1:0]  idx;
	logic                  wr_en;
	logic [DATA_WIDTH-1:0] gain_p_q, gain_i_q, gain_d_q, gain_windup_q;
	logic [DATA_WIDTH-1:0] limit_low_q, limit_high_q;
	pidq_flags_t           flags_q;

	assign idx    = paddr[ADDR_WIDTH-1:IDX_LSB];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			gain_windup_q <= '0;
			limit_low_q   <= '0;
			limit_high_q  <= '0;
			flags_q       <= '0;
		end else if (wr_en) begin
			unique case (pidq_reg_t'(idx))
				REG_GAIN_P:      gain_p_q      <= pwdata[DATA_WIDTH-1:0];
				REG_GAIN_I:      gain_i_q      <= pwdata[DATA_WIDTH-1:0];
				REG_GAIN_D:      gain_d_q      <= pwdata[DATA_WIDTH-1:0];
				REG_GAIN_WINDUP: gain_windup_q <= pwdata[DATA_WIDTH-1:0];
				REG_LIMIT_LOW:   limit_low_q   <= pwdata[DATA_WIDTH-1:0];
				REG_LIMIT_HIGH:  limit_high_q  <= pwdata[DATA_WIDTH-1:0];
				REG_FLAGS:       flags_q       <= pidq_flags_t'(pwdata[FLAGS_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (pidq_reg_t'(idx))
			REG_GAIN_P:      prdata[DATA_WIDTH-1:0] = gain_p_q;
			REG_GAIN_I:      prdata[DATA_WIDTH-1:0] = gain_i_q;
			REG_GAIN_D:      prdata[DATA_WIDTH-1:0] = gain_d_q;
			REG_GAIN_WINDUP: prdata[DATA_WIDTH-1:0] = gain_windup_q;
			REG_LIMIT_LOW:   prdata[DATA_WIDTH-1:0] = limit_low_q;
			REG_LIMIT_HIGH:  prdata[DATA_WIDTH-1:0] = limit_high_q;
			REG_FLAGS:       prdata[FLAGS_W-1:0]    = flags_q;
			default: ;
		endcase
	end

	assign gain_p      = gain_p_q;
	assign gain_i      = gain_i_q;
	assign gain_d      = gain_d_q;
	assign gain_windup = gain_windup_q;
	assign limit_low   = limit_low_q;
	assign limit_high  = limit_high_q;
	assign flags       = flags_q;

endmodule

// File: hdl/pidq_serial_mul.sv
`timescale 1ns / 1ps

module pidq_serial_mul import pidq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] op_a,
	input  logic [DATA_WIDTH-1:0] op_b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] product
);

	localparam int ACC_W = DATA_WIDTH + 2;
	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

	logic                  busy_q, done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] a_q, low_q;
	logic [ACC_W-1:0]      acc_q;
	logic [ACC_W-1:0]      a_ext, addend, acc_sum;

	// Multiplier bits are consumed LSB first from low_q; product bits shift in
	// from the top. The sign bit of op_b carries negative weight, hence the
	// subtraction on the last step.
	assign a_ext = {{2{a_q[DATA_WIDTH-1]}}, a_q};

	always_comb begin
		addend = '0;
		if (low_q[0]) begin
			addend = (cnt_q == LAST) ? (~a_ext + ACC_W'(1)) : a_ext;
		end
		acc_sum = acc_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			low_q <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_sum[ACC_W-1], acc_sum[ACC_W-1:1]};
			low_q <= {acc_sum[0], low_q[DATA_WIDTH-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {acc_q[FRAC_BITS-1:0], low_q[DATA_WIDTH-1:FRAC_BITS]};

endmodule

// File: hdl/pid_regulator_q16.sv
`timescale 1ns / 1ps

// Fixed-point PI/PID regulator with output clamping, integral reset and
// back-calculation anti-windup.
// The step channel carries a command and an error sample. A run command gives
// one transaction on the drive channel; a clear command zeroes the integrator
// and the windup feedback on acceptance and gives no drive transaction.
// A run step uses one shift-and-add multiplier four times in a row (integral,
// proportional, windup and derivative products), each retiring one multiplier
// bit per cycle. The result passes through the output state into the output
// register; the next step can be accepted in the same cycle as the result is
// offered. One step is worked on at a time; step.ready is high only while the
// sequencer is idle. The result sits in an output register, so the next step
// is accepted while it waits. If the receiver still stalls when the following
// result is done, that result is held until the output register frees up.
// Reset clears the configuration registers, the integrator, the windup
// feedback and the previous error. The user must send configuration through
// the APB port only while idle; the block itself does not enforce this.
module pid_regulator_q16 import pidq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int PDATA_WIDTH = (DATA_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_WIDTH  = REG_IDX_W + ((DATA_WIDTH > 32) ? 3 : 2)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pidq_step_if.sink              step,
	pidq_drive_if.source           drive,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_WIDTH-1:0]  paddr,
	input  logic [PDATA_WIDTH-1:0] pwdata,
	output logic [PDATA_WIDTH-1:0] prdata,
	output logic                   pready
);

	logic [DATA_WIDTH-1:0] gain_p, gain_i, gain_d, gain_windup;
	logic [DATA_WIDTH-1:0] limit_low, limit_high;
	pidq_flags_t           flags;

	pidq_state_t           state_q;
	logic [DATA_WIDTH-1:0] integ_q, wf_q, prev_q, err_q, sum_q, drive_q;
	logic                  drive_valid_q;

	logic                  mul_start, mul_done;
	logic [DATA_WIDTH-1:0] op_a, op_b, product;
	logic                  step_acc;
	logic [DATA_WIDTH-1:0] raw, pi_out, d_sum, pid_out;
	logic                  above, below, err_pos, err_neg, int_clear;

	function automatic logic [DATA_WIDTH-1:0] clamp_fn(
		input logic [DATA_WIDTH-1:0] v,
		input logic [DATA_WIDTH-1:0] lo,
		input logic [DATA_WIDTH-1:0] hi
	);
		logic [DATA_WIDTH-1:0] r;
		r = v;
		if ($signed(hi) < $signed(v)) begin
			r = hi;
		end else if ($signed(v) < $signed(lo)) begin
			r = lo;
		end
		return r;
	endfunction

	pidq_regs #(
		.DATA_WIDTH  (DATA_WIDTH),
		.ADDR_WIDTH  (ADDR_WIDTH),
		.PDATA_WIDTH (PDATA_WIDTH)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.gain_p      (gain_p),
		.gain_i      (gain_i),
		.gain_d      (gain_d),
		.gain_windup (gain_windup),
		.limit_low   (limit_low),
		.limit_high  (limit_high),
		.flags       (flags)
	);

	pidq_serial_mul #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (op_a),
		.op_b    (op_b),
		.done    (mul_done),
		.product (product)
	);

	assign step.ready = (state_q == ST_IDLE);
	assign step_acc   = step.valid && step.ready;

	// PI sum and first clamp, valid while the proportional product is done.
	assign raw     = product + integ_q;
	assign above   = $signed(limit_high) < $signed(raw);
	assign below   = !above && ($signed(raw) < $signed(limit_low));
	assign pi_out  = flags.pi_clamp ? clamp_fn(raw, limit_low, limit_high) : raw;
	assign err_pos = !err_q[DATA_WIDTH-1] && (err_q != '0);
	assign err_neg = err_q[DATA_WIDTH-1];
	assign int_clear = flags.pi_clamp && flags.int_reset &&
		((above && err_pos) || (below && err_neg));

	// Derivative path, valid while the derivative product is done.
	assign d_sum = sum_q + product;
	always_comb begin
		pid_out = sum_q;
		if (flags.pid_mode) begin
			pid_out = flags.pid_clamp ? clamp_fn(d_sum, limit_low, limit_high) : d_sum;
		end
	end

	always_comb begin
		mul_start = 1'b0;
		op_a      = '0;
		op_b      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (step_acc && (step.command == CMD_RUN)) begin
					mul_start = 1'b1;
					op_a      = gain_i;
					op_b      = step.error_in - wf_q;
				end
			end
			ST_MUL_I: begin
				mul_start = mul_done;
				op_a      = gain_p;
				op_b      = err_q;
			end
			ST_MUL_P: begin
				mul_start = mul_done;
				op_a      = gain_windup;
				op_b      = raw - pi_out;
			end
			ST_MUL_W: begin
				mul_start = mul_done;
				op_a      = gain_d;
				op_b      = err_q - prev_q;
			end
			ST_MUL_D, ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			integ_q       <= '0;
			wf_q          <= '0;
			prev_q        <= '0;
			drive_valid_q <= 1'b0;
		end else begin
			// In the output state the load below sets valid whenever ready is high.
			if (drive.ready && (state_q != ST_OUT)) begin
				drive_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (step_acc) begin
						if (step.command == CMD_CLEAR) begin
							integ_q <= '0;
							wf_q    <= '0;
						end else begin
							state_q <= ST_MUL_I;
						end
					end
				end
				ST_MUL_I: begin
					if (mul_done) begin
						integ_q <= integ_q + product;
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: begin
					if (mul_done) begin
						if (int_clear) begin
							integ_q <= '0;
							wf_q    <= '0;
						end
						state_q <= ST_MUL_W;
					end
				end
				ST_MUL_W: begin
					if (mul_done) begin
						// With anti-windup on, the windup term overrides a clear made by the integral reset.
						if (flags.anti_windup) begin
							wf_q <= product;
						end
						state_q <= ST_MUL_D;
					end
				end
				ST_MUL_D: begin
					if (mul_done) begin
						if (flags.pid_mode) begin
							prev_q <= err_q;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!drive_valid_q || drive.ready) begin
						drive_valid_q <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_acc) begin
			err_q <= step.error_in;
		end
		if ((state_q == ST_MUL_P) && mul_done) begin
			sum_q <= pi_out;
		end
		if ((state_q == ST_MUL_D) && mul_done) begin
			sum_q <= pid_out;
		end
		if ((state_q == ST_OUT) && (!drive_valid_q || drive.ready)) begin
			drive_q <= sum_q;
		end
	end

	assign drive.valid     = drive_valid_q;
	assign drive.drive_out = drive_q;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(step_acc && (step.command == CMD_CLEAR)) |=> (integ_q == '0) && (wf_q == '0))
		else $error("clear transaction did not zero integrator and feedback");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(step_acc && (step.command == CMD_RUN)) |=> (state_q == ST_MUL_I))
		else $error("run transaction did not start the integral product");

	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> ((state_q == ST_MUL_I) || (state_q == ST_MUL_P) ||
		(state_q == ST_MUL_W) || (state_q == ST_MUL_D)))
		else $error("multiplier finished outside a product step");

	a_prev_in_pid: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(prev_q) |-> $past((state_q == ST_MUL_D) && flags.pid_mode))
		else $error("previous error changed outside the derivative step");

	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && (!drive_valid_q || drive.ready) |=> drive_valid_q)
		else $error("finished result was not offered");

endmodule
